FILE: rtl/core/cqf_pkg.sv
// ----------------------------------------------------------------------------
// cqf_pkg
// Types, codes and sizes shared by the circular queue FIFO modules.
// ----------------------------------------------------------------------------
package cqf_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_ENQ     = 2'd0;
  localparam logic [1:0] REQ_DEQ     = 2'd1;
  localparam logic [1:0] REQ_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  // Per-cycle command to the cell chain.
  typedef struct packed {
    logic             enq;
    logic             pop;
    logic             rot;
    logic [CNT_W-1:0] count;
  } chain_op_t;

  // Per-cell controls.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: rtl/core/cqf_cell.sv
// ----------------------------------------------------------------------------
// cqf_cell
// One storage cell of the queue chain: load a word or take the neighbor's.
// ----------------------------------------------------------------------------
module cqf_cell (
  input  logic               clk,
  input  cqf_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] load_data,
  input  logic signed [31:0] next_data,
  output logic signed [31:0] data
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= next_data;
    end
  end

endmodule

FILE: rtl/core/cqf_chain.sv
// ----------------------------------------------------------------------------
// cqf_chain
// Row of cells; cell 0 holds the oldest word. Pop shifts toward cell 0,
// rotate also wraps the head word to the newest occupied cell.
// ----------------------------------------------------------------------------
module cqf_chain (
  input  logic                clk,
  input  cqf_pkg::chain_op_t  op,
  input  logic signed [31:0]  push_value,
  output logic signed [31:0]  head
);

  logic signed [31:0] cell_data [cqf_pkg::DEPTH];
  logic signed [31:0] load_data;

  assign head      = cell_data[0];
  assign load_data = op.rot ? cell_data[0] : push_value;

  for (genvar i = 0; i < cqf_pkg::DEPTH; i++) begin : g_cell
    cqf_pkg::cell_ctl_t ctl;
    logic signed [31:0] next_data;

    assign ctl.load  = (op.enq && (op.count == cqf_pkg::CNT_W'(i))) ||
                       (op.rot && (op.count == cqf_pkg::CNT_W'(i + 1)));
    assign ctl.shift = op.pop || op.rot;

    if (i == cqf_pkg::DEPTH - 1) begin : g_tail
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i + 1];
    end

    cqf_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_data (load_data),
      .next_data (next_data),
      .data      (cell_data[i])
    );
  end

endmodule

FILE: rtl/core/circular_queue_fifo.sv
// ----------------------------------------------------------------------------
// circular_queue_fifo
// FIFO of signed 32-bit words with enqueue, dequeue and display requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | cqf_pkg::req_t
//  rsp     | out | rsp_valid/rsp_stall | cqf_pkg::rsp_t
//
//  One enqueue or dequeue transfer per cycle is possible while rsp is not stalled.
//  Display returns each stored word (or an ST_EMPTY status if empty) as the cell
//  chain rotates one word per cycle unless rsp stalls; req is stalled meanwhile.
//  Reset empties the queue and clears the response valid.
//  A stalled rsp holds its word and blocks req until it is taken.
// ----------------------------------------------------------------------------
module circular_queue_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cqf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cqf_pkg::rsp_t rsp
);

  logic [cqf_pkg::CNT_W-1:0] count;
  logic [cqf_pkg::CNT_W-1:0] count_next;
  logic [cqf_pkg::CNT_W-1:0] disp_left;
  logic [cqf_pkg::CNT_W-1:0] left_cur;
  logic [cqf_pkg::CNT_W-1:0] left_next;

  logic               out_free;
  logic               disp_busy;
  logic               acc;
  logic               is_enq;
  logic               is_deq;
  logic               is_disp;
  logic               full;
  logic               empty;
  logic               enq_ok;
  logic               pop_ok;
  logic               disp_start;
  logic               disp_step;
  logic               load_out;
  logic signed [31:0] head;
  cqf_pkg::rsp_t      rsp_next;
  cqf_pkg::chain_op_t op;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign disp_busy = (disp_left != '0);
  assign req_stall = disp_busy || !out_free;
  assign acc       = req_valid && !req_stall;

  assign is_enq  = acc && (req.req_type == cqf_pkg::REQ_ENQ);
  assign is_deq  = acc && (req.req_type == cqf_pkg::REQ_DEQ);
  assign is_disp = acc && (req.req_type == cqf_pkg::REQ_DISPLAY);

  assign full  = (count == cqf_pkg::CNT_W'(cqf_pkg::DEPTH));
  assign empty = (count == '0);

  assign enq_ok     = is_enq && !full;
  assign pop_ok     = is_deq && !empty;
  assign disp_start = is_disp && !empty;
  assign disp_step  = disp_start || (disp_busy && out_free);

  assign left_cur  = disp_start ? count : disp_left;
  assign left_next = left_cur - cqf_pkg::CNT_W'(1);

  assign load_out = is_enq || is_deq || is_disp || disp_step;

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + cqf_pkg::CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - cqf_pkg::CNT_W'(1);
    end
  end

  // Response word for whatever transfer happens this cycle.
  always_comb begin
    rsp_next.result_value = '0;
    rsp_next.status       = cqf_pkg::ST_OK;
    rsp_next.last         = 1'b1;
    priority if (disp_step) begin
      rsp_next.result_value = head;
      rsp_next.last         = (left_next == '0);
    end else if (is_enq) begin
      rsp_next.status = full ? cqf_pkg::ST_OVERFLOW : cqf_pkg::ST_OK;
    end else if (is_deq) begin
      rsp_next.result_value = empty ? 32'sd0 : head;
      rsp_next.status       = empty ? cqf_pkg::ST_UNDERFLOW : cqf_pkg::ST_OK;
    end else if (is_disp) begin
      rsp_next.status = cqf_pkg::ST_EMPTY;
    end else begin
      rsp_next.last = 1'b1;
    end
  end

  assign op.enq   = enq_ok;
  assign op.pop   = pop_ok;
  assign op.rot   = disp_step;
  assign op.count = count;

  cqf_chain u_chain (
    .clk        (clk),
    .op         (op),
    .push_value (req.push_value),
    .head       (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      disp_left <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (disp_step) begin
        disp_left <= left_next;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload register, held while the consumer stalls.
  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= rsp_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cqf_pkg::CNT_W'(cqf_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_disp_no_accept: assert property (@(posedge clk) disable iff (rst)
    disp_busy |-> !acc)
    else $error("request accepted during display");

  a_disp_holds_count: assert property (@(posedge clk) disable iff (rst)
    disp_busy |=> count == $past(count))
    else $error("entry count changed during display");

  a_last_ends_disp: assert property (@(posedge clk) disable iff (rst)
    (disp_step && rsp_next.last) |=> !disp_busy)
    else $error("display still busy after last word");

  a_disp_left_range: assert property (@(posedge clk) disable iff (rst)
    disp_left <= count)
    else $error("display counter exceeds entry count");

endmodule
